FILE: hw/rtl/vfpp_pkg.sv
`default_nettype none
package vfpp_pkg;
	localparam int MaxFaces = 64;
	localparam int IdxW = $clog2(MaxFaces);
	localparam int CntW = $clog2(MaxFaces + 1);
	localparam int CoordW = 32;
	localparam int HalfW = 31;
	localparam int ProdW = 62;
	localparam int SumW = 64;
	localparam int CfgIdxW = 2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_QUERY_X = 2'd0,
		REG_QUERY_Y = 2'd1,
		REG_QUERY_Z = 2'd2
	} reg_idx_t;

	typedef logic signed [HalfW-1:0] half_t;

	// control from sequencer to dot-product unit
	typedef struct packed {
		logic       clear;
		logic       acc;
		logic [1:0] sel_a;
		logic [1:0] sel_b;
	} mac_ctl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/vfpp_ram.sv
`default_nettype none
module vfpp_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/vfpp_mac.sv
`default_nettype none
module vfpp_mac (
	input  wire logic               clk,
	input  wire vfpp_pkg::mac_ctl_t ctl,
	input  wire vfpp_pkg::half_t    a,
	input  wire vfpp_pkg::half_t    b,
	output logic signed [vfpp_pkg::SumW-1:0] sum
);
	import vfpp_pkg::*;

	logic signed [ProdW-1:0] prod_q;
	logic                    acc_s1;
	logic                    clr_s1;
	logic signed [SumW-1:0]  sum_q;

	// one 31x31 multiply, registered, then accumulate
	always_ff @(posedge clk) begin
		prod_q <= ProdW'(a * b);
		acc_s1 <= ctl.acc;
		clr_s1 <= ctl.clear;
		if (clr_s1) begin
			sum_q <= '0;
		end else if (acc_s1) begin
			sum_q <= sum_q + SumW'(prod_q);
		end
	end

	assign sum = sum_q;
endmodule
`default_nettype wire

FILE: hw/rtl/voronoi_face_plane_pruner.sv
// channel  | strobe / accept   | payload
// config   | cfg_we            | cfg_index, cfg_data
// neighbor | start && !busy    | point_x, point_y, point_z, final_point
// face     | result_valid      | face_x..z, face_total, no_faces, store_overflow, end_of_run
// A neighbor is accepted, then |h|^2 is formed (clear, multiplies, drain); then each stored plane
// visited is read, v.h and |v|^2 are formed, and a decide state drops h, deletes the plane or moves on;
// a deletion reads and writes back each later plane one slot down, then the slot is read again.
// A kept h is appended; a final neighbor then emits the stored faces one at a time (read, show).
// arst_n clears the sequencer, count, overflow flag and query registers; stored planes are not cleared.
// Results cannot be stalled; busy stays high until the last face is shown.
`default_nettype none
module voronoi_face_plane_pruner (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [vfpp_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [vfpp_pkg::CoordW-1:0]  cfg_data,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic signed [vfpp_pkg::CoordW-1:0] point_x,
	input  wire logic signed [vfpp_pkg::CoordW-1:0] point_y,
	input  wire logic signed [vfpp_pkg::CoordW-1:0] point_z,
	input  wire logic                    final_point,
	output logic                         result_valid,
	output logic signed [vfpp_pkg::HalfW-1:0] face_x,
	output logic signed [vfpp_pkg::HalfW-1:0] face_y,
	output logic signed [vfpp_pkg::HalfW-1:0] face_z,
	output logic [vfpp_pkg::CntW-1:0]   face_total,
	output logic                         no_faces,
	output logic                         store_overflow,
	output logic                         end_of_run
);
	import vfpp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HH, ST_RD, ST_DOT, ST_DEC, ST_SHR, ST_SHW,
		ST_APP, ST_EMR, ST_EMO, ST_EMPTY
	} state_t;

	localparam int HalfMax = (1 << (HalfW - 1)) - 1;
	localparam int HalfMin = -(1 << (HalfW - 1));

	state_t state_q;
	logic signed [CoordW-1:0] qx_q, qy_q, qz_q;
	half_t hx_q, hy_q, hz_q;
	half_t vx_q, vy_q, vz_q;
	logic signed [SumW-1:0] hh_q, dot_q;
	logic [CntW-1:0] count_q, j_q, k_q;
	logic [3:0] step_q;
	logic ovf_q, final_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUERY_X: qx_q <= cfg_data;
				REG_QUERY_Y: qy_q <= cfg_data;
				REG_QUERY_Z: qz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// half-vector with floor halving and saturation
	function automatic half_t half_sat(input logic signed [CoordW-1:0] p,
		input logic signed [CoordW-1:0] q);
		logic signed [CoordW:0] d;
		logic signed [CoordW-1:0] h;
		begin
			d = (CoordW+1)'(p) - (CoordW+1)'(q);
			h = d[CoordW:1];
			if (h > CoordW'(HalfMax)) begin
				half_sat = half_t'(HalfMax);
			end else if (h < CoordW'(HalfMin)) begin
				half_sat = half_t'(HalfMin);
			end else begin
				half_sat = h[HalfW-1:0];
			end
		end
	endfunction

	// store RAMs
	logic ram_we;
	logic [IdxW-1:0] ram_waddr, ram_raddr;
	half_t wx, wy, wz, rx, ry, rz;

	vfpp_ram #(.Width(HalfW), .Depth(MaxFaces)) u_ram_x (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wx), .raddr(ram_raddr), .rdata(rx));
	vfpp_ram #(.Width(HalfW), .Depth(MaxFaces)) u_ram_y (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wy), .raddr(ram_raddr), .rdata(ry));
	vfpp_ram #(.Width(HalfW), .Depth(MaxFaces)) u_ram_z (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wz), .raddr(ram_raddr), .rdata(rz));

	// shared multiplier; operand selects 0:x 1:y 2:z
	mac_ctl_t ctl;
	half_t ma, mb;
	logic signed [SumW-1:0] sum;

	vfpp_mac u_mac (.clk(clk), .ctl(ctl), .a(ma), .b(mb), .sum(sum));

	// sequencer step schedule for one dot product of three terms:
	// step 0 clear, 1..3 issue products, 4 drain, sum valid at step 5
	function automatic half_t pick(input logic [1:0] s, input half_t x, input half_t y,
		input half_t z);
		case (s)
			2'd0: pick = x;
			2'd1: pick = y;
			default: pick = z;
		endcase
	endfunction

	// the ST_DOT state runs two passes: steps 0..5 give v.h, steps 8..13 give v.v
	logic [3:0] sub;
	assign sub = {1'b0, step_q[2:0]};

	logic [1:0] term;
	assign term = 2'(sub - 4'd1);

	logic mac_run;
	assign mac_run = (state_q == ST_HH) || (state_q == ST_DOT);

	always_comb begin
		ctl.clear = (sub == 4'd0) && mac_run;
		ctl.acc = (sub >= 4'd1) && (sub <= 4'd3) && mac_run;
		ctl.sel_a = term;
		ctl.sel_b = term;
		ma = (state_q == ST_DOT) ? pick(ctl.sel_a, vx_q, vy_q, vz_q)
			: pick(ctl.sel_a, hx_q, hy_q, hz_q);
		mb = (state_q == ST_DOT && step_q[3]) ? pick(ctl.sel_b, vx_q, vy_q, vz_q)
			: pick(ctl.sel_b, hx_q, hy_q, hz_q);
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = j_q[IdxW-1:0];
		wx = hx_q;
		wy = hy_q;
		wz = hz_q;
		ram_raddr = j_q[IdxW-1:0];
		if (state_q == ST_SHW) begin
			ram_we = 1'b1;
			ram_waddr = k_q[IdxW-1:0];
			wx = rx;
			wy = ry;
			wz = rz;
		end else if (state_q == ST_APP && count_q < CntW'(MaxFaces)) begin
			ram_we = 1'b1;
			ram_waddr = count_q[IdxW-1:0];
		end
		if (state_q == ST_SHR) begin
			ram_raddr = IdxW'(k_q + 1'b1);
		end else if (state_q == ST_EMR || state_q == ST_EMO) begin
			ram_raddr = k_q[IdxW-1:0];
		end
	end

	logic hit;
	assign hit = (point_x == qx_q) && (point_y == qy_q) && (point_z == qz_q);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			result_valid <= 1'b0;
			step_q <= '0;
			j_q <= '0;
			k_q <= '0;
			final_q <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						final_q <= final_point;
						hx_q <= half_sat(point_x, qx_q);
						hy_q <= half_sat(point_y, qy_q);
						hz_q <= half_sat(point_z, qz_q);
						step_q <= '0;
						j_q <= '0;
						if (hit) begin
							state_q <= final_point ? ST_EMR : ST_IDLE;
							k_q <= '0;
							if (final_point && count_q == '0) state_q <= ST_EMPTY;
						end else begin
							state_q <= ST_HH;
						end
					end
				end
				ST_HH: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd5) begin
						hh_q <= sum;
						step_q <= '0;
						state_q <= (count_q == '0) ? ST_APP : ST_RD;
					end
				end
				ST_RD: begin
					// wait for RAM read of plane j
					step_q <= step_q + 4'd1;
					if (step_q == 4'd1) begin
						vx_q <= rx;
						vy_q <= ry;
						vz_q <= rz;
						step_q <= '0;
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					step_q <= step_q + 4'd1;
					if (sub == 4'd5) begin
						if (!step_q[3]) begin
							dot_q <= sum;
							step_q <= 4'd8;
						end else begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_DEC: begin
					step_q <= '0;
					if (dot_q > sum) begin
						state_q <= final_q ? ST_EMR : ST_IDLE;
						k_q <= '0;
						if (final_q && count_q == '0) state_q <= ST_EMPTY;
					end else if (dot_q > hh_q) begin
						count_q <= count_q - 1'b1;
						k_q <= j_q;
						state_q <= (j_q + 1'b1 < count_q) ? ST_SHR : ST_RD;
						if (j_q + 1'b1 >= count_q) begin
							state_q <= ST_APP;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= (j_q + 1'b1 < count_q) ? ST_RD : ST_APP;
					end
				end
				ST_SHR: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd1) begin
						step_q <= '0;
						state_q <= ST_SHW;
					end
				end
				ST_SHW: begin
					k_q <= k_q + 1'b1;
					state_q <= (k_q + 1'b1 < count_q) ? ST_SHR : ST_RD;
				end
				ST_APP: begin
					if (count_q < CntW'(MaxFaces)) begin
						count_q <= count_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
					k_q <= '0;
					state_q <= final_q ? ST_EMR : ST_IDLE;
				end
				ST_EMR: begin
					state_q <= ST_EMO;
				end
				ST_EMO: begin
					result_valid <= 1'b1;
					face_x <= rx;
					face_y <= ry;
					face_z <= rz;
					face_total <= count_q;
					no_faces <= 1'b0;
					store_overflow <= ovf_q;
					end_of_run <= (k_q + 1'b1 == count_q);
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 == count_q) begin
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EMR;
					end
				end
				ST_EMPTY: begin
					result_valid <= 1'b1;
					face_x <= '0;
					face_y <= '0;
					face_z <= '0;
					face_total <= '0;
					no_faces <= 1'b1;
					store_overflow <= ovf_q;
					end_of_run <= 1'b1;
					ovf_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	// checks on the store walk and emission
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxFaces)) else $error("face count beyond store depth");
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOT) |-> (j_q < count_q)) else $error("walk past stored planes");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && end_of_run) |-> (count_q == '0 && !ovf_q))
		else $error("count not cleared after run");
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && no_faces) |-> end_of_run) else $error("empty result not last");
endmodule
`default_nettype wire
